/* hw/rtl/lpfr_pkg.sv */
`timescale 1ns / 1ps

package lpfr_pkg;

   // Frame layout
   localparam int HEADER_BYTES   = 13;
   localparam int WINDOW_DEPTH   = 5;
   localparam int MSG_LO_POS     = 5;
   localparam int MSG_HI_POS     = 6;
   localparam int SEQ_LO_POS     = 11;
   localparam int SEQ_HI_POS     = 12;
   localparam int HDR_LAST_POS   = HEADER_BYTES - 1;

   // Defaults
   localparam int DEFAULT_POSITION_BITS = 16;
   localparam logic [15:0] RESET_MAX_LENGTH = 16'd8192;
   localparam logic [7:0] MAX_CLASS = 8'd1;

   // Commit of a found header candidate, hunter to tracker
   typedef struct packed {
      logic        commit;
      logic        frame_class;
      logic [15:0] frame_length;
   } lpfr_commit_type;

   // One result as it sits in the output buffer
   typedef struct packed {
      logic        is_header;
      logic        frame_class;
      logic [15:0] frame_length;
      logic [15:0] message_number;
      logic [15:0] sequence_number;
      logic [7:0]  payload_byte;
      logic        frame_last;
   } lpfr_result_type;

endpackage

/* hw/rtl/lpfr_req_if.sv */
`timescale 1ns / 1ps

interface lpfr_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] stream_byte;

   modport source (output valid, output stream_byte, input ready);
   modport sink (input valid, input stream_byte, output ready);
endinterface

/* hw/rtl/lpfr_rsp_if.sv */
`timescale 1ns / 1ps

interface lpfr_rsp_if;
   logic        valid;
   logic        ready;
   logic        is_header;
   logic        frame_class;
   logic [15:0] frame_length;
   logic [15:0] message_number;
   logic [15:0] sequence_number;
   logic [7:0]  payload_byte;
   logic        frame_last;

   modport source (
      output valid, output is_header, output frame_class, output frame_length,
      output message_number, output sequence_number, output payload_byte,
      output frame_last, input ready
   );
   modport sink (
      input valid, input is_header, input frame_class, input frame_length,
      input message_number, input sequence_number, input payload_byte,
      input frame_last, output ready
   );
endinterface

/* hw/rtl/lpfr_hunt.sv */
`timescale 1ns / 1ps

// Header hunter: five-byte candidate window, class and length checks.
module lpfr_hunt
   import lpfr_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            step,
   input  logic [7:0]      in_byte,
   input  logic [15:0]     max_length,
   output lpfr_commit_type commit_out
);

   logic [7:0] win_ff [4];
   logic [7:0] win_in [4];
   logic [2:0] fill_ff;
   logic [2:0] fill_in;

   logic [7:0]  ext [WINDOW_DEPTH];
   logic [7:0]  rest [4];
   logic [15:0] len_lo;
   logic        len_ok;
   logic [2:0]  skip;

   // Window with the new byte appended, and the length check on it
   always_comb begin
      for (int i = 0; i < 4; i++) begin
         ext[i] = win_ff[i];
      end
      ext[4] = '0;
      ext[fill_ff] = in_byte;
      len_lo = {ext[2], ext[1]};
      len_ok = (ext[3] == 8'd0) && (ext[4] == 8'd0) &&
               (len_lo >= 16'(HEADER_BYTES)) && (len_lo <= max_length);
      for (int i = 0; i < 4; i++) begin
         rest[i] = ext[i + 1];
      end
      // first byte that can open a frame after dropping the head
      skip = 3'd4;
      for (int i = 3; i >= 0; i--) begin
         if (rest[i] <= MAX_CLASS) begin
            skip = 3'(i);
         end
      end
   end

   // Next window state
   always_comb begin
      win_in = win_ff;
      fill_in = fill_ff;
      commit_out.commit = 1'b0;
      commit_out.frame_class = ext[0][0];
      commit_out.frame_length = len_lo;
      if (step) begin
         if (fill_ff == 3'd0) begin
            if (in_byte <= MAX_CLASS) begin
               win_in[0] = in_byte;
               fill_in = 3'd1;
            end
         end else if (fill_ff < 3'd4) begin
            win_in[fill_ff[1:0]] = in_byte;
            fill_in = fill_ff + 3'd1;
         end else if (len_ok) begin
            commit_out.commit = 1'b1;
            fill_in = 3'd0;
            for (int i = 0; i < 4; i++) begin
               win_in[i] = '0;
            end
         end else begin
            // bad length: drop the head, then any leading bad class bytes
            for (int i = 0; i < 4; i++) begin
               win_in[i] = '0;
               for (int j = 0; j < 4; j++) begin
                  if (3'(j) == 3'(i) + skip) begin
                     win_in[i] = rest[j];
                  end
               end
            end
            fill_in = 3'd4 - skip;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
         for (int i = 0; i < 4; i++) begin
            win_ff[i] <= '0;
         end
      end else begin
         fill_ff <= fill_in;
         win_ff <= win_in;
      end
   end

endmodule

/* hw/rtl/lpfr_track.sv */
`timescale 1ns / 1ps

// Frame tracker: byte position, header field capture and result forming.
module lpfr_track
   import lpfr_pkg::*;
#(
   parameter int POSITION_BITS = DEFAULT_POSITION_BITS
)
(
   input  logic            clock,
   input  logic            reset,
   input  logic            step,
   input  logic [7:0]      in_byte,
   input  lpfr_commit_type commit_in,
   output logic            in_frame,
   output logic            res_valid,
   output lpfr_result_type res
);

   localparam int CMP_BITS = (POSITION_BITS > 16) ? POSITION_BITS : 16;

   logic                     in_frame_ff, in_frame_in;
   logic [POSITION_BITS-1:0] pos_ff, pos_in;
   logic                     class_ff, class_in;
   logic [15:0]              length_ff, length_in;
   logic [15:0]              msg_ff, msg_in;
   logic [15:0]              seq_ff, seq_in;

   logic [CMP_BITS-1:0] pos_ext;
   logic [CMP_BITS-1:0] last_ext;
   logic                at_last;

   assign in_frame = in_frame_ff;
   assign pos_ext  = CMP_BITS'(pos_ff);
   assign last_ext = CMP_BITS'(length_ff - 16'd1);
   assign at_last  = (pos_ext == last_ext);

   always_comb begin
      in_frame_in = in_frame_ff;
      pos_in = pos_ff;
      class_in = class_ff;
      length_in = length_ff;
      msg_in = msg_ff;
      seq_in = seq_ff;
      res_valid = 1'b0;
      if (step) begin
         if (!in_frame_ff) begin
            // new frame from the hunter
            if (commit_in.commit) begin
               in_frame_in = 1'b1;
               pos_in = POSITION_BITS'(WINDOW_DEPTH);
               class_in = commit_in.frame_class;
               length_in = commit_in.frame_length;
               msg_in = '0;
               seq_in = '0;
            end
         end else begin
            // header field capture
            if (pos_ext == CMP_BITS'(MSG_LO_POS)) begin
               msg_in[7:0] = in_byte;
            end else if (pos_ext == CMP_BITS'(MSG_HI_POS)) begin
               msg_in[15:8] = in_byte;
            end else if (pos_ext == CMP_BITS'(SEQ_LO_POS)) begin
               seq_in[7:0] = in_byte;
            end else if (pos_ext == CMP_BITS'(SEQ_HI_POS)) begin
               seq_in[15:8] = in_byte;
            end
            res_valid = (pos_ext >= CMP_BITS'(HDR_LAST_POS));
            if ((pos_ext >= CMP_BITS'(HDR_LAST_POS)) && at_last) begin
               in_frame_in = 1'b0;
               pos_in = '0;
            end else begin
               pos_in = pos_ff + POSITION_BITS'(1);
            end
         end
      end
   end

   // result fields; header result carries a zero data byte
   always_comb begin
      res.is_header = (pos_ext == CMP_BITS'(HDR_LAST_POS));
      res.frame_class = class_ff;
      res.frame_length = length_ff;
      res.message_number = msg_in;
      res.sequence_number = seq_in;
      res.payload_byte = res.is_header ? 8'd0 : in_byte;
      res.frame_last = at_last;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_frame_ff <= 1'b0;
         pos_ff <= '0;
         class_ff <= 1'b0;
         length_ff <= '0;
         msg_ff <= '0;
         seq_ff <= '0;
      end else begin
         in_frame_ff <= in_frame_in;
         pos_ff <= pos_in;
         class_ff <= class_in;
         length_ff <= length_in;
         msg_ff <= msg_in;
         seq_ff <= seq_in;
      end
   end

endmodule

/* hw/rtl/lpfr_out_buf.sv */
`timescale 1ns / 1ps

// Two-entry result buffer; decouples the tracker from a stalled receiver.
module lpfr_out_buf
   import lpfr_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            push,
   input  lpfr_result_type push_data,
   output logic            not_full,
   lpfr_rsp_if.source      rsp_bus
);

   lpfr_result_type mem_ff [2];
   logic            wr_ptr_ff;
   logic            rd_ptr_ff;
   logic [1:0]      count_ff;
   logic            pop;
   lpfr_result_type head;

   assign not_full = (count_ff != 2'd2);
   assign pop = (count_ff != 2'd0) && rsp_bus.ready;
   assign head = mem_ff[rd_ptr_ff];

   assign rsp_bus.valid           = (count_ff != 2'd0);
   assign rsp_bus.is_header       = head.is_header;
   assign rsp_bus.frame_class     = head.frame_class;
   assign rsp_bus.frame_length    = head.frame_length;
   assign rsp_bus.message_number  = head.message_number;
   assign rsp_bus.sequence_number = head.sequence_number;
   assign rsp_bus.payload_byte    = head.payload_byte;
   assign rsp_bus.frame_last      = head.frame_last;

   // storage
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   // pointers and occupancy
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= ~wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= ~rd_ptr_ff;
         end
         count_ff <= count_ff + 2'(push) - 2'(pop);
      end
   end

endmodule

/* hw/rtl/length_prefixed_frame_resync.sv */
`timescale 1ns / 1ps

// Length-prefixed frame resynchronizer.
// req_bus carries one stream byte per request (valid/ready). The block hunts
// for a 13-byte header: class byte 0 or 1, little-endian 32-bit total length
// in 13..max, and commits the frame. On the 13th frame byte it sends a header
// result on rsp_bus, then one result per payload byte; frame_last marks the
// final result. csr_write_en/csr_write_data set the maximum frame length
// (reset value 8192); write it only while the block is idle.
// Throughput: one byte per cycle while the result buffer has room. A byte
// passes through the input register, then the tracker writes its result into
// the result buffer, from which rsp_bus presents it to the receiver.
// A two-entry result buffer lets requests keep flowing while a result waits;
// when the receiver stalls and the buffer fills, req_bus.ready drops after
// the input register holds one more byte.
// Reset (synchronous, active high) empties the window, leaves any frame and
// clears the buffer; no clearing pass is needed.
module length_prefixed_frame_resync
   import lpfr_pkg::*;
#(
   parameter int POSITION_BITS = DEFAULT_POSITION_BITS
)
(
   input  logic        clock,
   input  logic        reset,
   lpfr_req_if.sink    req_bus,
   lpfr_rsp_if.source  rsp_bus,
   input  logic        csr_write_en,
   input  logic [15:0] csr_write_data
);

   logic            s1_valid_ff;
   logic [7:0]      s1_byte_ff;
   logic [15:0]     max_len_ff;
   logic            advance;
   logic            buf_not_full;
   logic            in_frame;
   logic            res_valid;
   lpfr_commit_type commit;
   lpfr_result_type res;

   assign advance = s1_valid_ff && buf_not_full;
   assign req_bus.ready = !s1_valid_ff || advance;

   // input register and max length register
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         max_len_ff <= RESET_MAX_LENGTH;
      end else begin
         if (req_bus.ready) begin
            s1_valid_ff <= req_bus.valid;
         end
         if (csr_write_en) begin
            max_len_ff <= csr_write_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_bus.valid && req_bus.ready) begin
         s1_byte_ff <= req_bus.stream_byte;
      end
   end

   lpfr_hunt u_hunt (
      .clock      (clock),
      .reset      (reset),
      .step       (advance && !in_frame),
      .in_byte    (s1_byte_ff),
      .max_length (max_len_ff),
      .commit_out (commit)
   );

   lpfr_track #(
      .POSITION_BITS (POSITION_BITS)
   ) u_track (
      .clock     (clock),
      .reset     (reset),
      .step      (advance),
      .in_byte   (s1_byte_ff),
      .commit_in (commit),
      .in_frame  (in_frame),
      .res_valid (res_valid),
      .res       (res)
   );

   lpfr_out_buf u_out_buf (
      .clock     (clock),
      .reset     (reset),
      .push      (res_valid),
      .push_data (res),
      .not_full  (buf_not_full),
      .rsp_bus   (rsp_bus)
   );

endmodule

/* tb/tb.sv */
`timescale 1ns / 1ps

module tb;
   import lpfr_pkg::*;

   localparam int CYCLE_LIMIT     = 200_000;
   localparam int QUIET_CYCLES    = 8;
   localparam int HOLD_OFF_CYCLES = 400;
   localparam int DIRECTED_COUNT  = 25;

   // How a directed row is checked: by the predictor, as giving no result, or by a value typed in the row
   typedef enum logic [1:0] {ROW_PREDICTED, ROW_NO_RESULT, ROW_RESULT} row_check_type;

   typedef struct packed {
      logic [7:0]      stream_byte;
      row_check_type   check;
      lpfr_result_type result;
   } stim_row_type;

   localparam lpfr_result_type NO_RESULT = '0;
   // Class 0, length 13, message 0x1234, sequence 0xABCD: header result is also last
   localparam lpfr_result_type HEADER_ONLY = '{
      is_header: 1'b1, frame_class: 1'b0, frame_length: 16'd13,
      message_number: 16'h1234, sequence_number: 16'hABCD,
      payload_byte: 8'h00, frame_last: 1'b1
   };

   logic        clock;
   logic        reset;
   logic        csr_write_en;
   logic [15:0] csr_write_data;

   lpfr_req_if req_bus ();
   lpfr_rsp_if rsp_bus ();

   length_prefixed_frame_resync dut (
      .clock          (clock),
      .reset          (reset),
      .req_bus        (req_bus),
      .rsp_bus        (rsp_bus),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data)
   );

   // Deframer shadow state
   logic [7:0]  hunt_window [WINDOW_DEPTH];
   int unsigned hunt_fill;
   bit          tracking;
   logic [15:0] frame_pos;
   logic        held_class;
   logic [15:0] held_length;
   logic [15:0] held_message;
   logic [15:0] held_sequence;
   logic [15:0] max_length;

   lpfr_result_type frame_results_due [$];
   stim_row_type    directed_rows [DIRECTED_COUNT];

   int sender_idle_pct;
   int receiver_idle_pct;
   int mismatch_count;
   int cycle_count;
   bit hold_off_request;
   int hold_off_left;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Run limit
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb: errors");
         $finish;
      end
   end

   task shift_window();
      for (int i = 1; i < WINDOW_DEPTH; i++)
         hunt_window[i - 1] = hunt_window[i];
      hunt_window[WINDOW_DEPTH - 1] = 8'h00;
      if (hunt_fill > 0)
         hunt_fill--;
   endtask

   // Advance the deframer by one stream byte; returns the result it causes, if any
   task deframe_byte(input logic [7:0] b, output bit produced, output lpfr_result_type res);
      logic [15:0] last_pos;
      logic [31:0] claimed;
      bit          settled;
      produced = 1'b0;
      res = NO_RESULT;
      if (tracking) begin
         last_pos = held_length - 16'd1;
         case (frame_pos)
            MSG_LO_POS: held_message[7:0] = b;
            MSG_HI_POS: held_message[15:8] = b;
            SEQ_LO_POS: held_sequence[7:0] = b;
            SEQ_HI_POS: held_sequence[15:8] = b;
            default: ;
         endcase
         if (frame_pos >= HDR_LAST_POS) begin
            produced = 1'b1;
            res.is_header       = (frame_pos == HDR_LAST_POS);
            res.frame_class     = held_class;
            res.frame_length    = held_length;
            res.message_number  = held_message;
            res.sequence_number = held_sequence;
            res.payload_byte    = (frame_pos == HDR_LAST_POS) ? 8'h00 : b;
            res.frame_last      = (frame_pos == last_pos);
         end
         if (frame_pos >= HDR_LAST_POS && frame_pos == last_pos) begin
            tracking = 1'b0;
            frame_pos = '0;
         end else begin
            frame_pos = frame_pos + 16'd1;
         end
      end else begin
         if (hunt_fill >= WINDOW_DEPTH)
            hunt_fill = WINDOW_DEPTH - 1;
         hunt_window[hunt_fill] = b;
         hunt_fill++;
         settled = 1'b0;
         // Drop bad class bytes and bad lengths until the window waits or commits
         while (hunt_fill > 0 && !settled) begin
            if (hunt_window[0] > MAX_CLASS) begin
               shift_window();
            end else if (hunt_fill < WINDOW_DEPTH) begin
               settled = 1'b1;
            end else begin
               claimed = {hunt_window[4], hunt_window[3], hunt_window[2], hunt_window[1]};
               if (claimed < HEADER_BYTES || claimed > max_length) begin
                  shift_window();
               end else begin
                  held_class    = hunt_window[0][0];
                  held_length   = claimed[15:0];
                  held_message  = '0;
                  held_sequence = '0;
                  tracking      = 1'b1;
                  frame_pos     = 16'(WINDOW_DEPTH);
                  hunt_fill     = 0;
                  foreach (hunt_window[i]) hunt_window[i] = 8'h00;
                  settled = 1'b1;
               end
            end
         end
      end
   endtask

   // One request: random idle, offer, wait for acceptance, then predict
   task automatic send_request(input logic [7:0] b, input row_check_type check,
                               input lpfr_result_type fixed_result);
      bit              produced;
      lpfr_result_type predicted;
      while ($urandom_range(0, 99) < sender_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.stream_byte <= b;
      do @(posedge clock); while (!req_bus.ready);
      deframe_byte(b, produced, predicted);
      if (check == ROW_RESULT)
         frame_results_due.push_back(fixed_result);
      else if (check == ROW_PREDICTED && produced)
         frame_results_due.push_back(predicted);
   endtask

   // First count bytes of a frame: class, length word, then random header and payload
   task automatic send_frame(input logic cls, input logic [31:0] length_word,
                             input int unsigned count);
      for (int i = 0; i < count; i++) begin
         if (i == 0)
            send_request({7'd0, cls}, ROW_PREDICTED, NO_RESULT);
         else if (i < WINDOW_DEPTH)
            send_request(length_word[8 * (i - 1) +: 8], ROW_PREDICTED, NO_RESULT);
         else
            send_request(8'($urandom_range(0, 255)), ROW_PREDICTED, NO_RESULT);
      end
   endtask

   task wait_results_drained();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (frame_results_due.size() != 0)
         @(posedge clock);
   endtask

   task set_max_length(input logic [15:0] value);
      wait_results_drained();
      // Let the input register and the hunter settle on bytes with no result
      repeat (QUIET_CYCLES) @(posedge clock);
      csr_write_en <= 1'b1;
      csr_write_data <= value;
      @(posedge clock);
      csr_write_en <= 1'b0;
      max_length = value;
   endtask

   // Mostly well-formed frames; the rest bad lengths and line noise
   task automatic run_random(input int unsigned budget);
      int unsigned sent;
      int unsigned total;
      int unsigned pick;
      logic [31:0] claimed;
      sent = 0;
      while (sent < budget) begin
         pick = $urandom_range(0, 99);
         if (pick < 72) begin
            total = ($urandom_range(0, 9) == 0) ? $urandom_range(49, 260)
                                                : $urandom_range(13, 48);
            if (max_length >= HEADER_BYTES &&
                (total > max_length || (max_length <= 300 && $urandom_range(0, 7) == 0)))
               total = max_length;
            send_frame(1'($urandom_range(0, 1)), total, total);
            sent += total;
         end else if (pick < 84) begin
            case ($urandom_range(0, 2))
               0: claimed = $urandom_range(0, HEADER_BYTES - 1);
               1: claimed = max_length + 1 + $urandom_range(0, 300);
               default: claimed = $urandom;
            endcase
            send_frame(1'($urandom_range(0, 1)), claimed, WINDOW_DEPTH);
         end else begin
            repeat ($urandom_range(1, 6))
               send_request(8'($urandom_range(0, 255)), ROW_PREDICTED, NO_RESULT);
         end
      end
   endtask

   // Compare one field of an accepted result
   task check_field(input string field, input logic [15:0] want, input logic [15:0] got);
      if (got !== want) begin
         $display("%0t: %s expected %0h got %0h", $time, field, want, got);
         mismatch_count++;
      end
   endtask

   task check_result();
      lpfr_result_type want;
      if (frame_results_due.size() == 0) begin
         $display("%0t: result expected none got header %0b payload %0h last %0b", $time,
                  rsp_bus.is_header, rsp_bus.payload_byte, rsp_bus.frame_last);
         mismatch_count++;
      end else begin
         want = frame_results_due.pop_front();
         check_field("is_header", 16'(want.is_header), 16'(rsp_bus.is_header));
         check_field("frame_class", 16'(want.frame_class), 16'(rsp_bus.frame_class));
         check_field("frame_length", want.frame_length, rsp_bus.frame_length);
         check_field("message_number", want.message_number, rsp_bus.message_number);
         check_field("sequence_number", want.sequence_number, rsp_bus.sequence_number);
         check_field("payload_byte", 16'(want.payload_byte), 16'(rsp_bus.payload_byte));
         check_field("frame_last", 16'(want.frame_last), 16'(rsp_bus.frame_last));
      end
   endtask

   // Result side: check, then random stalls or a long hold-off
   initial begin
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_bus.valid && rsp_bus.ready)
            check_result();
         if (hold_off_request) begin
            hold_off_left = HOLD_OFF_CYCLES;
            hold_off_request = 1'b0;
         end
         if (hold_off_left > 0) begin
            hold_off_left--;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= ($urandom_range(0, 99) >= receiver_idle_pct);
         end
      end
   end

   initial begin
      reset <= 1'b1;
      csr_write_en <= 1'b0;
      csr_write_data <= '0;
      req_bus.valid <= 1'b0;
      req_bus.stream_byte <= '0;
      foreach (hunt_window[i]) hunt_window[i] = 8'h00;
      hunt_fill = 0;
      tracking = 1'b0;
      frame_pos = '0;
      held_class = 1'b0;
      held_length = '0;
      held_message = '0;
      held_sequence = '0;
      max_length = RESET_MAX_LENGTH;
      mismatch_count = 0;
      cycle_count = 0;
      hold_off_request = 1'b0;
      hold_off_left = 0;
      sender_idle_pct = 20;
      receiver_idle_pct = 70;

      directed_rows = '{
         // bad class bytes are skipped
         '{8'hFF, ROW_NO_RESULT, NO_RESULT},
         '{8'h02, ROW_NO_RESULT, NO_RESULT},
         // header-only frame, committed on the last length byte
         '{8'h00, ROW_NO_RESULT, NO_RESULT},
         '{8'h0D, ROW_NO_RESULT, NO_RESULT},
         '{8'h00, ROW_NO_RESULT, NO_RESULT},
         '{8'h00, ROW_NO_RESULT, NO_RESULT},
         '{8'h00, ROW_NO_RESULT, NO_RESULT},
         '{8'h34, ROW_NO_RESULT, NO_RESULT},
         '{8'h12, ROW_NO_RESULT, NO_RESULT},
         '{8'h00, ROW_NO_RESULT, NO_RESULT},
         '{8'h00, ROW_NO_RESULT, NO_RESULT},
         '{8'h00, ROW_NO_RESULT, NO_RESULT},
         '{8'h00, ROW_NO_RESULT, NO_RESULT},
         '{8'hCD, ROW_NO_RESULT, NO_RESULT},
         '{8'hAB, ROW_RESULT, HEADER_ONLY},
         // length far above the maximum
         '{8'h01, ROW_PREDICTED, NO_RESULT},
         '{8'hFF, ROW_PREDICTED, NO_RESULT},
         '{8'hFF, ROW_PREDICTED, NO_RESULT},
         '{8'hFF, ROW_PREDICTED, NO_RESULT},
         '{8'hFF, ROW_PREDICTED, NO_RESULT},
         // length below the header size
         '{8'h00, ROW_PREDICTED, NO_RESULT},
         '{8'h05, ROW_PREDICTED, NO_RESULT},
         '{8'h00, ROW_PREDICTED, NO_RESULT},
         '{8'h00, ROW_PREDICTED, NO_RESULT},
         '{8'h00, ROW_PREDICTED, NO_RESULT}
      };

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[r])
         send_request(directed_rows[r].stream_byte, directed_rows[r].check,
                      directed_rows[r].result);

      set_max_length(16'd200);
      run_random(140);
      // Leave a long frame open across the next write of a smaller maximum
      send_frame(1'b1, 32'd150, 20);

      set_max_length(16'd13);
      run_random(110);

      sender_idle_pct = 70;
      receiver_idle_pct = 20;
      // Below the header size: nothing may commit
      set_max_length(16'd12);
      run_random(60);

      set_max_length(16'hFFFF);
      run_random(150);

      sender_idle_pct = 0;
      receiver_idle_pct = 0;
      set_max_length(16'd40);
      run_random(120);

      set_max_length(RESET_MAX_LENGTH);
      // Receiver holds off while a long frame keeps coming, so the input stalls
      hold_off_request = 1'b1;
      send_frame(1'b0, 32'd120, 120);
      wait_results_drained();
      run_random(120);

      wait_results_drained();
      repeat (QUIET_CYCLES * 4) @(posedge clock);
      if (mismatch_count == 0)
         $display("tb: clean");
      else
         $display("tb: errors");
      $finish;
   end

endmodule

/* sim.f */
hw/rtl/lpfr_pkg.sv
hw/rtl/lpfr_req_if.sv
hw/rtl/lpfr_rsp_if.sv
hw/rtl/lpfr_hunt.sv
hw/rtl/lpfr_track.sv
hw/rtl/lpfr_out_buf.sv
hw/rtl/length_prefixed_frame_resync.sv
tb/tb.sv
